FILE: design/rbb_pkg.sv
// rbb_pkg: shared constants, command and queue status types, window helpers
// for the row box blur; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package rbb_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int MAX_WINDOW = 64;
	localparam int WIN_W      = $clog2(MAX_WINDOW) + 1;
	localparam int POS_W      = 7;
	localparam int POS_MAX    = (1 << POS_W) - 1;
	localparam int TAIL_W     = $clog2(MAX_WINDOW);
	localparam int HIST_DEPTH = 2 * MAX_WINDOW;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);
	localparam int SUM_W      = SAMPLE_W + $clog2(MAX_WINDOW);
	localparam int DIVC_W     = $clog2(SUM_W);
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = $clog2(QDEPTH + 1);
	localparam int CFG_W      = 7;
	localparam logic [CFG_W-1:0] WIN_RESET = CFG_W'(3);

	// one command per input item that produces results
	typedef struct packed {
		logic [POS_W-1:0]    pos;
		logic [SAMPLE_W-1:0] first;
		logic [HIST_AW-1:0]  newest;
		logic [WIN_W-1:0]    k;
		logic                eor;
	} cmd_t;

	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QCNT_W-1:0] cnt;
	} q_stat_t;

	// window width clamped to 1..MAX_WINDOW
	function automatic logic [WIN_W-1:0] eff_window(input logic [CFG_W-1:0] w);
		logic [WIN_W-1:0] k;
		begin
			if (w == '0) begin
				k = WIN_W'(1);
			end else if (32'(w) > MAX_WINDOW) begin
				k = WIN_W'(MAX_WINDOW);
			end else begin
				k = WIN_W'(w);
			end
			return k;
		end
	endfunction

	// samples needed to the right of the center: k - 1 - k/2
	function automatic logic [TAIL_W-1:0] tail_len(input logic [WIN_W-1:0] k);
		logic [WIN_W-1:0] d;
		begin
			d = k - WIN_W'(1) - (k >> 1);
			return d[TAIL_W-1:0];
		end
	endfunction

endpackage
`default_nettype wire

FILE: design/row_box_blur_clamped_top.sv
// row_box_blur_clamped_top: horizontal box blur with edge replication
// depends on rbb_pkg, rbb_ram, rbb_front, rbb_queue, rbb_back
//
// channel   dir  signals                          carries
// s_axis    in   tvalid tready tdata[15:0] tlast  sample, end_of_row
// m_axis    out  tvalid tready tdata[15:0] tlast  blurred, row_last
// cfg       in   valid ready data[6:0]            window_size
//
// each result takes a window sum (k history reads through the one ram read
// port, one tap a cycle, then the registered read and a drain), a bit-serial
// divide of the 22-bit sum and a load of the output register; each command is
// popped from idle; a row end flushes up to (k+1)/2 results
// reset is asynchronous; the history ram is not cleared, reads only reach
// samples of the current row, so there is no clearing pass
// intake stalls only when the two-entry command queue is full; the compute
// side waits while the output register holds an item not yet taken; the
// front may run at most 64 items ahead of the command being computed, whose
// reads reach at most 63 samples back, inside the 128-entry history ring
`timescale 1ns / 1ps
`default_nettype none
module row_box_blur_clamped_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [rbb_pkg::CFG_W-1:0]     cfg_data,      // window_size
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [rbb_pkg::SAMPLE_W-1:0]  s_axis_tdata,  // sample
	input  wire logic                          s_axis_tlast,  // end_of_row
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic [rbb_pkg::SAMPLE_W-1:0]       m_axis_tdata,  // blurred
	output logic                               m_axis_tlast   // row_last
);
	import rbb_pkg::*;

	// front to queue
	logic                push;
	cmd_t                cmd;
	// queue to back
	cmd_t                head;
	q_stat_t             q_stat;
	logic                pop;
	// history ring
	logic                hist_we;
	logic [HIST_AW-1:0]  hist_waddr;
	logic [SAMPLE_W-1:0] hist_wdata;
	logic [HIST_AW-1:0]  hist_raddr;
	logic [SAMPLE_W-1:0] hist_rdata;

	// intake: config, row position, history writes, command per result-bearing item
	rbb_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.q_stat        (q_stat),
		.push          (push),
		.cmd           (cmd),
		.hist_we       (hist_we),
		.hist_waddr    (hist_waddr),
		.hist_wdata    (hist_wdata)
	);

	// recent samples, newest at the write pointer
	rbb_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (HIST_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (hist_wdata),
		.raddr (hist_raddr),
		.rdata (hist_rdata)
	);

	// decouples intake from the slow compute side
	rbb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (cmd),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	// window sums, divide, output register
	rbb_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.q_stat        (q_stat),
		.pop           (pop),
		.hist_raddr    (hist_raddr),
		.hist_rdata    (hist_rdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// queue occupancy never exceeds its depth
	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.cnt <= QCNT_W'(QDEPTH))
		else $error("command queue overflow");

	// no command pushed into a full queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("push while queue full");

	// no command popped from an empty queue
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop while queue empty");

	// a pushed command always leaves the queue non-empty on the next cycle
	a_push_fill: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> !q_stat.empty)
		else $error("pushed command lost");
endmodule
`default_nettype wire

FILE: design/rbb_ram.sv
// rbb_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module rbb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

FILE: design/rbb_front.sv
// rbb_front: config register, sample intake, history write, command build
// depends on rbb_pkg
`timescale 1ns / 1ps
`default_nettype none
module rbb_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [rbb_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [rbb_pkg::SAMPLE_W-1:0]  s_axis_tdata,
	input  wire logic                          s_axis_tlast,
	input  wire rbb_pkg::q_stat_t              q_stat,
	output logic                               push,
	output rbb_pkg::cmd_t                      cmd,
	output logic                               hist_we,
	output logic [rbb_pkg::HIST_AW-1:0]        hist_waddr,
	output logic [rbb_pkg::SAMPLE_W-1:0]       hist_wdata
);
	import rbb_pkg::*;

	logic [CFG_W-1:0]    win_q;
	logic [POS_W-1:0]    pos_q;
	logic [SAMPLE_W-1:0] first_q;
	logic [HIST_AW-1:0]  wp_q;
	logic [WIN_W-1:0]    k_eff;
	logic [TAIL_W-1:0]   d;
	logic                accept;

	always_comb begin
		cfg_ready     = 1'b1;
		s_axis_tready = !q_stat.full;
		accept        = s_axis_tvalid && s_axis_tready;
		k_eff         = eff_window(win_q);
		d             = tail_len(k_eff);
		push          = accept && (s_axis_tlast || (pos_q >= POS_W'(d)));
		cmd.pos       = pos_q;
		cmd.first     = (pos_q == '0) ? s_axis_tdata : first_q;
		cmd.newest    = wp_q;
		cmd.k         = k_eff;
		cmd.eor       = s_axis_tlast;
		hist_we       = accept;
		hist_waddr    = wp_q;
		hist_wdata    = s_axis_tdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= WIN_RESET;
			pos_q   <= '0;
			first_q <= '0;
			wp_q    <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				win_q <= cfg_data;
			end
			if (accept) begin
				wp_q <= wp_q + HIST_AW'(1);
				if (pos_q == '0) begin
					first_q <= s_axis_tdata;
				end
				if (s_axis_tlast) begin
					pos_q <= '0;
				end else if (pos_q != POS_W'(POS_MAX)) begin
					pos_q <= pos_q + POS_W'(1);
				end
			end
		end
	end
endmodule
`default_nettype wire

FILE: design/rbb_queue.sv
// rbb_queue: small command fifo between intake and compute
// depends on rbb_pkg
`timescale 1ns / 1ps
`default_nettype none
module rbb_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire rbb_pkg::cmd_t push_cmd,
	input  wire logic          pop,
	output rbb_pkg::cmd_t      head,
	output rbb_pkg::q_stat_t   q_stat
);
	import rbb_pkg::*;

	cmd_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] rp_q;
	logic [QPTR_W-1:0] wp_q;
	logic [QCNT_W-1:0] cnt_q;

	always_comb begin
		head         = slot_q[rp_q];
		q_stat.cnt   = cnt_q;
		q_stat.full  = (cnt_q == QCNT_W'(QDEPTH));
		q_stat.empty = (cnt_q == '0);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q  <= '0;
			wp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + QPTR_W'(1);
			end
			if (pop) begin
				rp_q <= rp_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end
endmodule
`default_nettype wire

FILE: design/rbb_back.sv
// rbb_back: window sum over history ram, bit-serial divide, result register
// depends on rbb_pkg
`timescale 1ns / 1ps
`default_nettype none
module rbb_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire rbb_pkg::cmd_t                 head,
	input  wire rbb_pkg::q_stat_t              q_stat,
	output logic                               pop,
	output logic [rbb_pkg::HIST_AW-1:0]        hist_raddr,
	input  wire logic [rbb_pkg::SAMPLE_W-1:0]  hist_rdata,
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic [rbb_pkg::SAMPLE_W-1:0]       m_axis_tdata,
	output logic                               m_axis_tlast
);
	import rbb_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SUM  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t              state_q;
	cmd_t                cur_q;
	logic [TAIL_W-1:0]   r_q;
	logic [WIN_W-1:0]    j_q;
	logic [SUM_W-1:0]    sum_q;
	logic [WIN_W-2:0]    rem_q;
	logic [DIVC_W-1:0]   div_cnt_q;
	logic                v_s1;
	logic                first_s1;

	logic [TAIL_W-1:0]   head_d;
	logic [TAIL_W-1:0]   r_start;
	logic [WIN_W-1:0]    o;
	logic signed [POS_W+2:0] idx;
	logic signed [WIN_W:0]   age;
	logic                issue;
	logic [WIN_W-1:0]    rem_sh;
	logic [WIN_W-1:0]    rem_sub;
	logic                qbit;
	logic                out_free;
	logic                load_out;

	always_comb begin
		head_d  = tail_len(head.k);
		r_start = head_d;
		if (head.eor && (head.pos < POS_W'(head_d))) begin
			r_start = head.pos[TAIL_W-1:0];
		end
		pop = (state_q == ST_IDLE) && !q_stat.empty;

		// source index and age of tap j for the result r behind the newest sample
		o     = cur_q.k >> 1;
		idx   = $signed({3'b000, cur_q.pos}) + $signed((POS_W+3)'(j_q))
			- $signed((POS_W+3)'(r_q)) - $signed((POS_W+3)'(o));
		age   = $signed((WIN_W+1)'(r_q)) + $signed((WIN_W+1)'(o)) - $signed((WIN_W+1)'(j_q));
		issue = (state_q == ST_SUM) && (j_q < cur_q.k);
		if (age < 0) begin
			hist_raddr = cur_q.newest;
		end else begin
			hist_raddr = cur_q.newest - HIST_AW'(age[WIN_W-1:0]);
		end

		rem_sh  = {rem_q, sum_q[SUM_W-1]};
		rem_sub = rem_sh - cur_q.k;
		qbit    = (rem_sh >= cur_q.k);
		out_free = !m_axis_tvalid || m_axis_tready;
		load_out = (state_q == ST_OUT) && out_free;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			r_q           <= '0;
			j_q           <= '0;
			sum_q         <= '0;
			rem_q         <= '0;
			div_cnt_q     <= '0;
			v_s1          <= 1'b0;
			first_s1      <= 1'b0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
			m_axis_tlast  <= 1'b0;
		end else begin
			v_s1     <= issue;
			first_s1 <= (idx < 0);
			if (m_axis_tvalid && m_axis_tready && !load_out) begin
				m_axis_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						r_q     <= r_start;
						j_q     <= '0;
						sum_q   <= '0;
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					if (issue) begin
						j_q <= j_q + WIN_W'(1);
					end
					if (v_s1) begin
						sum_q <= sum_q + SUM_W'(first_s1 ? cur_q.first : hist_rdata);
					end else if (!issue) begin
						rem_q     <= '0;
						div_cnt_q <= '0;
						state_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (qbit) begin
						rem_q <= rem_sub[WIN_W-2:0];
					end else begin
						rem_q <= rem_sh[WIN_W-2:0];
					end
					sum_q     <= {sum_q[SUM_W-2:0], qbit};
					div_cnt_q <= div_cnt_q + DIVC_W'(1);
					if (div_cnt_q == DIVC_W'(SUM_W - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (load_out) begin
						m_axis_tvalid <= 1'b1;
						m_axis_tdata  <= sum_q[SAMPLE_W-1:0];
						m_axis_tlast  <= cur_q.eor && (r_q == '0);
						if (cur_q.eor && (r_q != '0)) begin
							r_q     <= r_q - TAIL_W'(1);
							j_q     <= '0;
							sum_q   <= '0;
							state_q <= ST_SUM;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire
